// ===== hw/rtl/lncm_pkg.sv =====
// Shared types, constants and a helper function of the Life neighbour count map.
package lncm_pkg;

  // Default map limits and register reset values.
  localparam int          DEF_MAX_WIDTH  = 64;
  localparam int          DEF_MAX_HEIGHT = 64;
  localparam logic [6:0]  SIZE_RESET     = 7'd64;
  localparam int          MIN_SIZE       = 3;

  // Configuration register indexes.
  localparam logic        REG_WIDTH  = 1'b0;
  localparam logic        REG_HEIGHT = 1'b1;

  // Life rule counts.
  localparam logic [3:0]  SURVIVE_COUNT = 4'd2;
  localparam logic [3:0]  BIRTH_COUNT   = 4'd3;
  localparam logic [3:0]  MAX_COUNT     = 4'd8;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_SNAP = 2'd1,
    CMD_EVAL = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  // One map entry: alive flag in bit 0, live neighbour count above it.
  typedef struct packed {
    logic [3:0] count;
    logic       alive;
  } entry_t;

  typedef struct packed {
    cmd_t       command;
    logic [5:0] col;
    logic [5:0] row;
  } req_t;

  typedef struct packed {
    logic       changed;
    logic [3:0] neighbour_count;
    logic       cell_alive;
  } res_t;

  // Add or remove one neighbour, saturating at zero and at eight.
  function automatic entry_t bump(entry_t e, logic up);
    entry_t r;
    r = e;
    if (up) begin
      if (e.count < MAX_COUNT) r.count = e.count + 4'd1;
    end else begin
      if (e.count != 4'd0) r.count = e.count - 4'd1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lncm_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module lncm_ram #(
  parameter int AW = 12,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lncm_ctrl.sv =====
// Command sequencer: clear pass, center lookup, neighbour updates and snapshot copy.
module lncm_ctrl #(
  parameter int MAX_WIDTH  = lncm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lncm_pkg::DEF_MAX_HEIGHT,
  parameter int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
  parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [6:0]             cfg_data,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  lncm_pkg::req_t         req,
  output logic                   res_valid,
  input  logic                   res_ready,
  output lncm_pkg::res_t         res,
  output logic                   live_we,
  output logic [CW+RW-1:0]       live_waddr,
  output lncm_pkg::entry_t       live_wdata,
  output logic [CW+RW-1:0]       live_raddr,
  input  lncm_pkg::entry_t       live_rdata,
  output logic                   snap_we,
  output logic [CW+RW-1:0]       snap_waddr,
  output lncm_pkg::entry_t       snap_wdata,
  output logic [CW+RW-1:0]       snap_raddr,
  input  lncm_pkg::entry_t       snap_rdata
);

  localparam int AW  = CW + RW;
  localparam int XW0 = $clog2(MAX_WIDTH + 1);
  localparam int YW0 = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = (XW0 > 7) ? XW0 : 7;
  localparam int YW  = (YW0 > 7) ? YW0 : 7;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_CHECK, S_NBR, S_COPY, S_DONE
  } state_t;

  state_t                state;
  logic [6:0]            map_width;
  logic [6:0]            map_height;
  lncm_pkg::req_t        req_q;
  logic [AW-1:0]         clr;
  logic [2:0]            k;
  logic                  up_q;
  logic [AW-1:0]         cp_rd;
  logic                  cp_reading;
  logic [AW-1:0]         cp_wa;
  logic                  cp_wv;

  logic [XW-1:0]         w_eff, w_raw, col_x, cl, cr;
  logic [YW-1:0]         h_eff, h_raw, row_y, ra, rb;
  logic                  on_map;
  logic                  chg;
  logic [AW-1:0]         nbr [8];
  logic [AW-1:0]         center;

  // Effective map size, clamped to the supported range.
  always_comb begin
    w_raw = XW'(map_width);
    h_raw = YW'(map_height);
    if (w_raw < XW'(lncm_pkg::MIN_SIZE))   w_eff = XW'(lncm_pkg::MIN_SIZE);
    else if (w_raw > XW'(MAX_WIDTH))       w_eff = XW'(MAX_WIDTH);
    else                                   w_eff = w_raw;
    if (h_raw < YW'(lncm_pkg::MIN_SIZE))   h_eff = YW'(lncm_pkg::MIN_SIZE);
    else if (h_raw > YW'(MAX_HEIGHT))      h_eff = YW'(MAX_HEIGHT);
    else                                   h_eff = h_raw;
  end

  // Wrapped neighbour coordinates of the latched cell.
  always_comb begin
    col_x  = XW'(req_q.col);
    row_y  = YW'(req_q.row);
    on_map = (col_x < w_eff) && (row_y < h_eff);
    cl = (col_x == '0) ? w_eff - XW'(1) : col_x - XW'(1);
    cr = (col_x == w_eff - XW'(1)) ? '0 : col_x + XW'(1);
    ra = (row_y == '0) ? h_eff - YW'(1) : row_y - YW'(1);
    rb = (row_y == h_eff - YW'(1)) ? '0 : row_y + YW'(1);
    center = {row_y[RW-1:0], col_x[CW-1:0]};
    nbr[0] = {ra[RW-1:0],    cl[CW-1:0]};
    nbr[1] = {ra[RW-1:0],    col_x[CW-1:0]};
    nbr[2] = {ra[RW-1:0],    cr[CW-1:0]};
    nbr[3] = {row_y[RW-1:0], cl[CW-1:0]};
    nbr[4] = {row_y[RW-1:0], cr[CW-1:0]};
    nbr[5] = {rb[RW-1:0],    cl[CW-1:0]};
    nbr[6] = {rb[RW-1:0],    col_x[CW-1:0]};
    nbr[7] = {rb[RW-1:0],    cr[CW-1:0]};
  end

  // Decision on the center cell, valid while the lookup data is present.
  always_comb begin
    case (req_q.command)
      lncm_pkg::CMD_SET:  chg = !live_rdata.alive;
      lncm_pkg::CMD_EVAL: begin
        if (snap_rdata.alive) begin
          chg = (snap_rdata.count != lncm_pkg::SURVIVE_COUNT) &&
                (snap_rdata.count != lncm_pkg::BIRTH_COUNT) && live_rdata.alive;
        end else begin
          chg = (snap_rdata.count == lncm_pkg::BIRTH_COUNT) && !live_rdata.alive;
        end
      end
      default: chg = 1'b0;
    endcase
    chg = chg && on_map;
  end

  // Memory port steering.
  always_comb begin
    live_we    = 1'b0;
    live_waddr = center;
    live_wdata = live_rdata;
    live_raddr = center;
    snap_we    = 1'b0;
    snap_waddr = cp_wa;
    snap_wdata = live_rdata;
    snap_raddr = center;
    unique case (state)
      S_CLEAR: begin
        live_we    = 1'b1;
        live_waddr = clr;
        live_wdata = '0;
        snap_we    = 1'b1;
        snap_waddr = clr;
        snap_wdata = '0;
      end
      S_CHECK: begin
        live_we          = chg;
        live_wdata.alive = !live_rdata.alive;
        live_raddr       = nbr[0];
      end
      S_NBR: begin
        live_we    = 1'b1;
        live_waddr = nbr[k];
        live_wdata = lncm_pkg::bump(live_rdata, up_q);
        live_raddr = nbr[k + 3'd1];
      end
      S_COPY: begin
        live_raddr = cp_rd;
        snap_we    = cp_wv;
      end
      default: begin
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      map_width  <= lncm_pkg::SIZE_RESET;
      map_height <= lncm_pkg::SIZE_RESET;
      clr        <= '0;
      cp_reading <= 1'b0;
      cp_wv      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lncm_pkg::REG_WIDTH) map_width  <= cfg_data;
        else                                  map_height <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (&clr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_CHECK;
        S_CHECK: begin
          res.cell_alive      <= on_map & (live_rdata.alive ^ chg);
          res.neighbour_count <= on_map ? live_rdata.count : 4'd0;
          res.changed         <= chg;
          up_q                <= !live_rdata.alive;
          k                   <= '0;
          cp_rd               <= '0;
          cp_reading          <= 1'b1;
          cp_wv               <= 1'b0;
          if (chg)                                   state <= S_NBR;
          else if (req_q.command == lncm_pkg::CMD_SNAP) state <= S_COPY;
          else                                       state <= S_DONE;
        end
        S_NBR: begin
          k <= k + 3'd1;
          if (&k) state <= S_DONE;
        end
        S_COPY: begin
          // Reads run one entry ahead of the snapshot writes.
          cp_wv <= cp_reading;
          cp_wa <= cp_rd;
          if (cp_reading) begin
            cp_rd <= cp_rd + AW'(1);
            if (&cp_rd) cp_reading <= 1'b0;
          end
          if (!cp_reading && !cp_wv) state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/life_neighbour_count_map.sv =====
// Top level of the Life neighbour count map: port unpacking, memories and output register.
// The map lives in two single-write RAMs, the live map and its snapshot, each entry holding
// an alive bit and a neighbour count. After reset a clearing pass zeroes both memories, one
// entry per cycle (MAX_WIDTH x MAX_HEIGHT rounded up to powers of two, 4096 entries by default),
// and no transaction is taken until it ends. A read, or a set or evaluate that changes nothing,
// passes through the fetch and check states to the done state, where its result is handed to
// the output register before the sequencer returns to idle for the next command. A set or
// evaluate that flips a cell first runs the pipelined read-modify-write of its eight
// neighbours in the neighbour state. A snapshot walks the whole live memory into the snapshot
// memory, one entry per cycle, in the copy state before its result is offered. One command is
// processed at a time; the next is accepted while a finished result waits in the output
// register. Configuration writes are taken at any time and should only be issued while
// the block is idle.
module life_neighbour_count_map #(
  parameter int MAX_WIDTH  = lncm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lncm_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // command[1:0], col[7:2], row[13:8], zero[15:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // cell_alive[0], neighbour_count[4:1], changed[5], zero[7:6]
);

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = CW + RW;
  localparam int DW = $bits(lncm_pkg::entry_t);

  lncm_pkg::req_t   req;
  lncm_pkg::res_t   res;
  logic             res_valid;
  logic             res_ready;
  logic             live_we, snap_we;
  logic [AW-1:0]    live_waddr, live_raddr, snap_waddr, snap_raddr;
  lncm_pkg::entry_t live_wdata, live_rdata, snap_wdata, snap_rdata;
  logic [DW-1:0]    live_rbits, snap_rbits;

  assign req.command = lncm_pkg::cmd_t'(s_tdata[1:0]);
  assign req.col     = s_tdata[7:2];
  assign req.row     = s_tdata[13:8];

  assign live_rdata = lncm_pkg::entry_t'(live_rbits);
  assign snap_rdata = lncm_pkg::entry_t'(snap_rbits);

  lncm_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .live_we    (live_we),
    .live_waddr (live_waddr),
    .live_wdata (live_wdata),
    .live_raddr (live_raddr),
    .live_rdata (live_rdata),
    .snap_we    (snap_we),
    .snap_waddr (snap_waddr),
    .snap_wdata (snap_wdata),
    .snap_raddr (snap_raddr),
    .snap_rdata (snap_rdata)
  );

  lncm_ram #(.AW(AW), .DW(DW)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rbits)
  );

  lncm_ram #(.AW(AW), .DW(DW)) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (snap_raddr),
    .rdata (snap_rbits)
  );

  // Output register: a finished result waits here while the next command starts.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_ready) m_tvalid <= res_valid;
    end
    if (res_ready && res_valid) m_tdata <= {2'b00, res};
  end

endmodule
